>>> hw/rtl/mexp_pkg.sv
`default_nettype none

package mexp_pkg;

  // fixed field widths of the channels and the register port
  localparam int FIELD_W   = 32;
  localparam int DATA_W    = 32;
  localparam int ADDR_W    = 3;
  localparam int WIDTH_DEF = 32;

  // register index, taken from paddr[2]
  localparam logic REG_EXPONENT = 1'b0;
  localparam logic REG_MODULUS  = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_REDUCE,
    ST_CHECK,
    ST_MUL_R,
    ST_SQR,
    ST_FINISH
  } state_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;       // capture operands, start base reduction
    logic red_step;   // one bit of base mod m
    logic mul_load;   // start a modular multiply
    logic mul_sq;     // multiply operand select: 1 squares b, 0 takes r * b
    logic mul_step;   // one bit of the shift-and-add multiply
    logic wb_r;       // product to r
    logic wb_b;       // product to b
    logic shift_e;    // next exponent bit
  } cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic mod_zero;
    logic red_done;
    logic mul_done;
    logic e_zero;
    logic e_bit0;
    logic e_last;
  } status_t;

endpackage

`default_nettype wire

>>> hw/rtl/mexp_if.sv
`default_nettype none

// input channel: one base word per handshake
interface mexp_in_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FIELD_W-1:0]  base_value;

  modport source (output valid, output base_value, input ready);
  modport sink   (input valid, input base_value, output ready);
endinterface

// result channel: one result word per handshake
interface mexp_out_if;
  logic                          valid;
  logic                          ready;
  logic [mexp_pkg::FIELD_W-1:0]  power_result;
  logic                          modulus_error;

  modport source (output valid, output power_result, output modulus_error, input ready);
  modport sink   (input valid, input power_result, input modulus_error, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/mexp_datapath.sv
`default_nettype none

module mexp_datapath #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  wire logic              clk,
  input  wire mexp_pkg::cmd_t    cmd,
  input  wire logic [WIDTH-1:0]  base,
  input  wire logic [WIDTH-1:0]  exponent,
  input  wire logic [WIDTH-1:0]  modulus,
  output mexp_pkg::status_t      status,
  output logic [WIDTH-1:0]       result,
  output logic                   mod_err
);

  localparam int CNT_W = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] m_r, e_r, b_r, r_r, src_r, acc_r, x_r, y_r;
  logic [CNT_W-1:0] cnt_r;

  logic [WIDTH:0]   red_t, red_v;
  logic [WIDTH:0]   acc_s, acc_v;
  logic [WIDTH:0]   dbl_s, dbl_v;
  logic [WIDTH:0]   m_ext;

  // operands below m, so one compare and subtract keeps each sum reduced
  always_comb begin
    m_ext = {1'b0, m_r};
    red_t = {b_r, src_r[WIDTH-1]};
    red_v = (red_t >= m_ext) ? red_t - m_ext : red_t;
    acc_s = {1'b0, acc_r} + {1'b0, x_r};
    acc_v = (acc_s >= m_ext) ? acc_s - m_ext : acc_s;
    dbl_s = {x_r, 1'b0};
    dbl_v = (dbl_s >= m_ext) ? dbl_s - m_ext : dbl_s;
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      m_r   <= modulus;
      e_r   <= exponent;
      src_r <= base;
      b_r   <= '0;
      cnt_r <= CNT_W'(WIDTH);
      r_r   <= (modulus == WIDTH'(1)) ? '0 : WIDTH'(1);
    end else if (cmd.red_step) begin
      b_r   <= red_v[WIDTH-1:0];
      src_r <= src_r << 1;
      cnt_r <= cnt_r - CNT_W'(1);
    end
    if (cmd.mul_load) begin
      x_r   <= b_r;
      y_r   <= cmd.mul_sq ? b_r : r_r;
      acc_r <= '0;
    end else if (cmd.mul_step) begin
      if (y_r[0]) begin
        acc_r <= acc_v[WIDTH-1:0];
      end
      x_r <= dbl_v[WIDTH-1:0];
      y_r <= y_r >> 1;
    end
    if (cmd.wb_r) begin
      r_r <= acc_r;
    end
    if (cmd.wb_b) begin
      b_r <= acc_r;
    end
    if (cmd.shift_e) begin
      e_r <= e_r >> 1;
    end
  end

  always_comb begin
    status.mod_zero = (m_r == '0);
    status.red_done = (cnt_r == '0);
    status.mul_done = (y_r == '0);
    status.e_zero   = (e_r == '0);
    status.e_bit0   = e_r[0];
    status.e_last   = ((e_r >> 1) == '0);
  end

  assign mod_err = (m_r == '0);
  assign result  = mod_err ? '0 : r_r;

endmodule

`default_nettype wire

>>> hw/rtl/mexp_ctrl.sv
`default_nettype none

module mexp_ctrl (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  input  wire logic         out_free,
  input  wire mexp_pkg::status_t status,
  output logic              in_ready,
  output logic              emit,
  output mexp_pkg::cmd_t    cmd
);

  mexp_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mexp_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mexp_pkg::ST_REDUCE;
      end
      mexp_pkg::ST_REDUCE: begin
        if (status.mod_zero)      state_nxt = mexp_pkg::ST_FINISH;
        else if (status.red_done) state_nxt = mexp_pkg::ST_CHECK;
      end
      mexp_pkg::ST_CHECK: begin
        if (status.e_zero)       state_nxt = mexp_pkg::ST_FINISH;
        else if (status.e_bit0)  state_nxt = mexp_pkg::ST_MUL_R;
        else                     state_nxt = mexp_pkg::ST_SQR;
      end
      mexp_pkg::ST_MUL_R: begin
        if (status.mul_done) begin
          state_nxt = status.e_last ? mexp_pkg::ST_FINISH : mexp_pkg::ST_SQR;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (status.mul_done) state_nxt = mexp_pkg::ST_CHECK;
      end
      mexp_pkg::ST_FINISH: begin
        if (out_free) state_nxt = mexp_pkg::ST_IDLE;
      end
      default: state_nxt = mexp_pkg::ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    emit     = 1'b0;
    case (state_r)
      mexp_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mexp_pkg::ST_REDUCE: begin
        cmd.red_step = !status.mod_zero && !status.red_done;
      end
      mexp_pkg::ST_CHECK: begin
        if (!status.e_zero) begin
          cmd.mul_load = 1'b1;
          cmd.mul_sq   = !status.e_bit0;
          cmd.shift_e  = !status.e_bit0;
        end
      end
      mexp_pkg::ST_MUL_R: begin
        if (status.mul_done) begin
          cmd.wb_r     = 1'b1;
          cmd.shift_e  = 1'b1;
          cmd.mul_load = !status.e_last;
          cmd.mul_sq   = 1'b1;
        end else begin
          cmd.mul_step = 1'b1;
        end
      end
      mexp_pkg::ST_SQR: begin
        if (status.mul_done) cmd.wb_b = 1'b1;
        else                 cmd.mul_step = 1'b1;
      end
      mexp_pkg::ST_FINISH: begin
        emit = out_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hw/rtl/modular_exponentiation_core.sv
`default_nettype none

// modular exponentiation core: base^exponent mod modulus, right-to-left binary
// channels:
//   in_ch  - one base word per handshake (valid/ready)
//   out_ch - one result word per handshake: power_result, modulus_error
//   apb    - exponent at byte 0, modulus at byte 4; both read back, reset value 1
// write the registers only while the core is idle; each item uses the values
// captured when the item is taken
// sequence per item, paced by the single shift-and-add modular multiplier that
// handles one multiplier bit per cycle:
//   the base is reduced mod m right after it is taken
//   per exponent bit: a check state, a multiply into r on a set bit, then a
//   squaring (skipped after the top bit), each running until its multiplier bits are used up
//   with m == 0 the reduction is skipped and the item goes straight to the end
// one item in flight at a time; in_ch.ready is high only while idle
// the result sits in an output register, so the next base is taken while the
// receiver stalls; the core then waits at the end of that item until the
// register frees up
// reset (rst_n low, synchronous) drops out valid, idles the sequencer and sets
// both registers to 1
// modulus 0 returns modulus_error = 1 with power_result = 0

module modular_exponentiation_core #(
  parameter int WIDTH = mexp_pkg::WIDTH_DEF
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  mexp_in_if.sink                          in_ch,
  mexp_out_if.source                       out_ch,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [mexp_pkg::ADDR_W-1:0] paddr,
  input  wire logic [mexp_pkg::DATA_W-1:0] pwdata,
  output logic      [mexp_pkg::DATA_W-1:0] prdata,
  output logic                             pready
);

  // configuration registers, kept at the operand width
  logic [WIDTH-1:0] exp_r, mod_r;
  logic             cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      exp_r <= WIDTH'(1);
      mod_r <= WIDTH'(1);
    end else if (cfg_wr) begin
      if (paddr[2] == mexp_pkg::REG_EXPONENT) exp_r <= WIDTH'(pwdata);
      else                                    mod_r <= WIDTH'(pwdata);
    end
  end

  assign prdata = (paddr[2] == mexp_pkg::REG_MODULUS) ? mexp_pkg::DATA_W'(mod_r)
                                                       : mexp_pkg::DATA_W'(exp_r);

  // sequencer and datapath
  mexp_pkg::cmd_t    cmd;
  mexp_pkg::status_t status;
  logic              emit;
  logic              out_free;
  logic [WIDTH-1:0]  dp_result;
  logic              dp_err;

  mexp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .out_free (out_free),
    .status   (status),
    .in_ready (in_ch.ready),
    .emit     (emit),
    .cmd      (cmd)
  );

  mexp_datapath #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk      (clk),
    .cmd      (cmd),
    .base     (WIDTH'(in_ch.base_value)),
    .exponent (exp_r),
    .modulus  (mod_r),
    .status   (status),
    .result   (dp_result),
    .mod_err  (dp_err)
  );

  // output register: free when empty or being taken this cycle
  logic                           out_valid_r;
  logic [mexp_pkg::FIELD_W-1:0]   out_result_r;
  logic                           out_err_r;

  assign out_free = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_result_r <= mexp_pkg::FIELD_W'(dp_result);
      out_err_r    <= dp_err;
    end
  end

  assign out_ch.valid         = out_valid_r;
  assign out_ch.power_result  = out_result_r;
  assign out_ch.modulus_error = out_err_r;

endmodule

`default_nettype wire

>>> hw/rtl/mexp_checker.sv
`default_nettype none

module mexp_checker (
  input wire logic                         clk,
  input wire logic                         rst_n,
  input wire logic                         in_valid,
  input wire logic                         in_ready,
  input wire logic                         out_valid,
  input wire logic                         out_ready,
  input wire logic [mexp_pkg::FIELD_W-1:0] power_result,
  input wire logic                         modulus_error
);

  // a stalled result word stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  // a stalled result word keeps its payload
  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(power_result) && $stable(modulus_error))
    else $error("result payload changed while stalled");

  // the error flag always comes with a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && modulus_error |-> power_result == '0)
    else $error("modulus error with nonzero result");

  // one item at a time: busy right after taking a base
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second base taken while busy");

  // reset empties the output register
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered after reset");

endmodule

bind modular_exponentiation_core mexp_checker u_mexp_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .power_result  (out_ch.power_result),
  .modulus_error (out_ch.modulus_error)
);

`default_nettype wire

>>> bench/mexp_checker.sv
`timescale 1ns / 1ps

module mexp_result_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  mexp_in_if                          in_mon,
  mexp_out_if                         out_mon,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [mexp_pkg::ADDR_W-1:0] paddr,
  input  logic [mexp_pkg::DATA_W-1:0] pwdata,
  input  logic [mexp_pkg::DATA_W-1:0] prdata,
  input  logic                        pready,
  input  logic                        run_done,
  output int                          fail_count
);
  import mexp_pkg::*;

  typedef struct packed {
    logic [FIELD_W-1:0] base_value;
    logic [FIELD_W-1:0] power_result;
    logic               modulus_error;
  } power_word_t;

  logic [FIELD_W-1:0] exponent_reg;
  logic [FIELD_W-1:0] modulus_reg;
  logic [DATA_W-1:0]  reg_want;
  power_word_t        pending_powers[$];
  power_word_t        want;
  int                 result_idx;
  logic               leftover_checked;

  initial begin
    fail_count       = 0;
    result_idx       = 0;
    leftover_checked = 1'b0;
  end

  task automatic note_mismatch(input string what);
    $display("[%0t] mismatch: %s", $time, what);
    fail_count++;
  endtask

  // right-to-left square and multiply, products exact in twice the width
  function automatic power_word_t power_mod(input logic [FIELD_W-1:0] base,
                                            input logic [FIELD_W-1:0] expo,
                                            input logic [FIELD_W-1:0] modv);
    logic [2*FIELD_W-1:0] acc;
    logic [2*FIELD_W-1:0] sq;
    power_word_t          word;
    word.base_value    = base;
    word.power_result  = '0;
    word.modulus_error = (modv == '0);
    if (!word.modulus_error) begin
      acc = 64'd1 % modv;
      sq  = base % modv;
      for (int i = 0; i < FIELD_W; i++) begin
        if (expo[i]) acc = (acc * sq) % modv;
        sq = (sq * sq) % modv;
      end
      word.power_result = acc[FIELD_W-1:0];
    end
    return word;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      exponent_reg = 1;
      modulus_reg  = 1;
      pending_powers.delete();
    end else begin
      // register port: mirror writes, check reads
      if (psel && penable && pready) begin
        if (pwrite) begin
          if (paddr[2] == REG_EXPONENT) exponent_reg = pwdata[FIELD_W-1:0];
          else modulus_reg = pwdata[FIELD_W-1:0];
        end else begin
          reg_want = (paddr[2] == REG_EXPONENT) ? exponent_reg : modulus_reg;
          if (prdata !== reg_want)
            note_mismatch($sformatf("read at address %0d: got %h, want %h",
                                    paddr, prdata, reg_want));
        end
      end
      // results first, so a word leaving and one arriving on the same edge pair up right
      if (out_mon.valid && out_mon.ready) begin
        if (pending_powers.size() == 0) begin
          note_mismatch($sformatf("result word %0d arrived with nothing expected",
                                  result_idx));
        end else begin
          want = pending_powers.pop_front();
          if (out_mon.power_result !== want.power_result)
            note_mismatch($sformatf("word %0d base %h: power_result %h, want %h",
                                    result_idx, want.base_value,
                                    out_mon.power_result, want.power_result));
          if (out_mon.modulus_error !== want.modulus_error)
            note_mismatch($sformatf("word %0d base %h: modulus_error %b, want %b",
                                    result_idx, want.base_value,
                                    out_mon.modulus_error, want.modulus_error));
        end
        result_idx++;
      end
      if (in_mon.valid && in_mon.ready)
        pending_powers.push_back(power_mod(in_mon.base_value, exponent_reg, modulus_reg));
      if (run_done && !leftover_checked) begin
        leftover_checked = 1'b1;
        if (pending_powers.size() != 0)
          note_mismatch($sformatf("%0d result words never arrived", pending_powers.size()));
      end
    end
  end

endmodule

>>> bench/tb_modular_exponentiation_core.sv
`timescale 1ns / 1ps

module tb_modular_exponentiation_core;
  import mexp_pkg::*;

  // rough count of base words to send over the whole run
  localparam int N_BASES = 280;
  // quiet cycles at the end, a bit over the worst per-word latency
  localparam int TAIL_CYCLES = 2300;

  logic              clk        = 1'b0;
  logic              rst_n      = 1'b0;
  logic              psel       = 1'b0;
  logic              penable    = 1'b0;
  logic              pwrite     = 1'b0;
  logic [ADDR_W-1:0] paddr      = '0;
  logic [DATA_W-1:0] pwdata     = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              run_done   = 1'b0;
  logic              sink_ready = 1'b0;

  // receiver pacing: current ready level is held until ready_hold counts down to zero
  int                ready_hold    = 0;
  int unsigned       rx_pick;
  // handshake counts, used to wait until the core has drained
  int                bases_sent    = 0;
  int                results_taken = 0;
  // modulus now in the core, steers the choice of bases
  logic [FIELD_W-1:0] cur_mod      = 1;
  int                fail_count;

  mexp_in_if  in_bus ();
  mexp_out_if out_bus ();

  assign out_bus.ready = sink_ready;

  modular_exponentiation_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_bus),
    .out_ch  (out_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  mexp_result_checker checker_i (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_bus),
    .out_mon    (out_bus),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .run_done   (run_done),
    .fail_count (fail_count)
  );

  // 4 ns clock
  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // result side stalls: mostly short dips, now and then one long enough that the
  // next base is taken while the output register is still full; high stretches
  // give runs with no stall at all
  always @(posedge clk) begin
    if (!rst_n) begin
      sink_ready <= 1'b0;
      ready_hold <= 0;
    end else begin
      if (out_bus.valid && sink_ready) results_taken <= results_taken + 1;
      if (ready_hold != 0) begin
        ready_hold <= ready_hold - 1;
      end else if (!sink_ready) begin
        sink_ready <= 1'b1;
        ready_hold <= $urandom_range(0, 300);
      end else begin
        rx_pick    = $urandom_range(0, 99);
        sink_ready <= 1'b0;
        if (rx_pick < 70) ready_hold <= $urandom_range(0, 3);
        else if (rx_pick < 92) ready_hold <= $urandom_range(4, 60);
        else ready_hold <= $urandom_range(200, 2500);
      end
    end
  end

  // one register access: setup phase, access phase, then idle with psel low
  task automatic reg_access(input logic wr, input logic idx, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
  endtask

  // offer one base word after a random gap; returns on the edge that takes it,
  // with valid left high so a back-to-back word needs no extra toggle
  task automatic push_base(input logic [FIELD_W-1:0] base);
    int unsigned pick;
    int unsigned gap;
    pick = $urandom_range(0, 99);
    if (pick < 55) gap = 0;
    else if (pick < 85) gap = $urandom_range(1, 3);
    else if (pick < 97) gap = $urandom_range(4, 20);
    else gap = $urandom_range(50, 150);
    if (gap != 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.base_value <= base;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    bases_sent++;
  endtask

  task automatic idle_sender();
    in_bus.valid <= 1'b0;
  endtask

  // every base gives exactly one result, so equal counts mean the core is idle
  task automatic wait_drained();
    while (results_taken < bases_sent) @(posedge clk);
  endtask

  // new register setting: only while idle, then read both back
  task automatic begin_phase(input logic [FIELD_W-1:0] expo, input logic [FIELD_W-1:0] modv,
                             input logic wr_exp, input logic wr_mod);
    idle_sender();
    wait_drained();
    if (wr_exp) reg_access(1'b1, REG_EXPONENT, expo);
    if (wr_mod) begin
      reg_access(1'b1, REG_MODULUS, modv);
      cur_mod = modv;
    end
    reg_access(1'b0, REG_EXPONENT, '0);
    reg_access(1'b0, REG_MODULUS, '0);
  endtask

  // mostly short exponents to keep the run quick, a few full-width ones
  function automatic logic [FIELD_W-1:0] random_exponent();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) return $urandom;
    else if (pick < 14) return '1;
    else if (pick < 20) return $urandom_range(0, 1);
    else return $urandom & ((32'd1 << $urandom_range(2, 12)) - 1);
  endfunction

  function automatic logic [FIELD_W-1:0] random_modulus();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    else if (pick < 10) return 1;
    else if (pick < 14) return 2;
    else if (pick < 20) return '1;
    else if (pick < 24) return 32'd1 << $urandom_range(2, 31);
    else if (pick < 50) return $urandom_range(3, 65535);
    else return $urandom;
  endfunction

  // bases: edges, at or just above the modulus, already reduced, or anything
  function automatic logic [FIELD_W-1:0] random_base(input logic [FIELD_W-1:0] modv);
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 5) return '0;
    else if (pick < 10) return '1;
    else if (pick < 20 && modv != 0) return modv + $urandom_range(0, 2);
    else if (pick < 45 && modv != 0) return $urandom_range(0, modv - 1);
    else return $urandom;
  endfunction

  initial begin
    int unsigned count;
    int unsigned pick;
    in_bus.valid      = 1'b0;
    in_bus.base_value = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // reset values: both registers read back as one, every base gives zero
    reg_access(1'b0, REG_EXPONENT, '0);
    reg_access(1'b0, REG_MODULUS, '0);
    push_base('0);
    push_base('1);

    // zero modulus flags an error and returns zero
    begin_phase(5, '0, 1'b1, 1'b1);
    push_base(7);
    push_base('1);

    // zero exponent gives one, including zero to the zero
    begin_phase('0, '1, 1'b1, 1'b1);
    push_base('0);
    push_base(12345);
    // zero exponent with modulus one still reduces to zero
    begin_phase('0, 1, 1'b0, 1'b1);
    push_base(9);

    // widest exponent and modulus, the slowest words
    begin_phase('1, '1, 1'b1, 1'b1);
    push_base('1);
    push_base(32'hFFFF_FFFE);
    push_base(2);

    // typical key-style exponent with a large prime modulus
    begin_phase(65537, 32'hFFFF_FFFB, 1'b1, 1'b1);
    push_base(32'h8000_0000);
    push_base(32'hDEAD_BEEF);

    // smallest nontrivial modulus
    begin_phase(3, 2, 1'b1, 1'b1);
    push_base('0);
    push_base(1);
    push_base('1);

    // bases at, above and just below the modulus
    begin_phase(7, 32'h8000_0000, 1'b1, 1'b1);
    push_base(32'h8000_0000);
    push_base(32'h8000_0001);
    push_base(32'h7FFF_FFFF);

    // alternating bit patterns through a squaring
    begin_phase(2, '1, 1'b1, 1'b1);
    push_base(32'hAAAA_AAAA);
    push_base(32'h5555_5555);

    // random settings, each followed by a batch of bases; sometimes only one
    // register changes, and now and then the sender waits for a full drain
    while (bases_sent < N_BASES) begin
      pick = $urandom_range(0, 3);
      begin_phase(random_exponent(), random_modulus(), pick != 1, pick != 2);
      count = $urandom_range(6, 24);
      repeat (count) begin
        if ($urandom_range(0, 15) == 0) begin
          idle_sender();
          wait_drained();
        end
        push_base(random_base(cur_mod));
      end
    end

    idle_sender();
    wait_drained();
    // watch for stray words after the last one, then ask for the leftover check
    repeat (TAIL_CYCLES) @(posedge clk);
    run_done <= 1'b1;
    repeat (2) @(posedge clk);
    if (fail_count == 0) begin
      $display("** modular_exponentiation_core: PASSED **");
    end else begin
      $display("** modular_exponentiation_core: FAILED **");
    end
    $finish;
  end

  // hang guard, several times the slowest legal run
  initial begin
    #30_000_000;
    $display("** modular_exponentiation_core: FAILED **");
    $finish;
  end

endmodule
